FILE: design/bcpd_pkg.sv
// shared types and constants for the button combo press detector
package bcpd_pkg;

   // register port geometry
   localparam int ADDR_WIDTH = 6;
   localparam int DATA_WIDTH = 64;

   // per-button field layout in the configuration registers
   localparam int SLOTS       = 4;
   localparam int PIN_WIDTH   = 8;
   localparam int HOLD_WIDTH  = 16;
   localparam int MODE_WIDTH  = 2;
   localparam int COUNT_REG_WIDTH = 3;

   // register reset values
   localparam logic [COUNT_REG_WIDTH-1:0] BUTTON_COUNT_RESET  = '0;
   localparam logic [SLOTS-1:0]           BUTTON_ENABLE_RESET = '1;

   // register map, index is paddr divided by eight
   typedef enum logic [2:0] {
      REG_BUTTON_COUNT  = 3'd0,
      REG_BUTTON_ENABLE = 3'd1,
      REG_COMBO_MASKS   = 3'd2,
      REG_HOLD_TICKS    = 3'd3,
      REG_EVENT_MODES   = 3'd4
   } reg_index_type;

   // event mode of one button
   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_OVERFLOW = 2'd0,
      MODE_BREAK    = 2'd1,
      MODE_STATUS   = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

endpackage

FILE: design/button_combo_press_detector_core.sv
// button combo press detector: scan tick in, one event report out per tick
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_pressed_pins
//   rsp_      out        rsp_valid / rsp_stall  rsp_event_valid, rsp_event_button,
//                                               rsp_event_latched, rsp_pushed_mask
//   csr_      in/out     apb style, pready = 1  64-bit registers at 8 * index
//
// one tick per cycle while rsp_ is not stalled; a tick's result passes through the input register,
// then the button priority chain into the result register, and shows on rsp_
// synchronous reset clears the counters, pushed flags, the event latch, both valids
// and the configuration registers to their defaults
// a stalled result holds the result register; the input register keeps taking ticks
// until it is full too, then req_stall goes high
module button_combo_press_detector_core #(
   parameter int BUTTONS     = 4,
   parameter int PINS        = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [bcpd_pkg::PIN_WIDTH-1:0]        req_pressed_pins,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_event_valid,
   output logic [1:0]                            rsp_event_button,
   output logic                                  rsp_event_latched,
   output logic [bcpd_pkg::SLOTS-1:0]            rsp_pushed_mask,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bcpd_pkg::ADDR_WIDTH-1:0]       csr_paddr,
   input  logic [bcpd_pkg::DATA_WIDTH-1:0]       csr_pwdata,
   output logic [bcpd_pkg::DATA_WIDTH-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   // pins above PINS are ignored
   localparam logic [bcpd_pkg::PIN_WIDTH-1:0] PIN_MASK =
      bcpd_pkg::PIN_WIDTH'((64'd1 << PINS) - 64'd1);

   // configuration registers
   logic [bcpd_pkg::COUNT_REG_WIDTH-1:0]  button_count_ff;
   logic [bcpd_pkg::SLOTS-1:0]            button_enable_ff;
   logic [bcpd_pkg::SLOTS*bcpd_pkg::PIN_WIDTH-1:0]  combo_masks_ff;
   logic [bcpd_pkg::SLOTS*bcpd_pkg::HOLD_WIDTH-1:0] hold_ticks_ff;
   logic [bcpd_pkg::SLOTS*bcpd_pkg::MODE_WIDTH-1:0] event_modes_ff;

   // button state
   logic [COUNT_WIDTH-1:0]  counter_ff [BUTTONS];
   logic [COUNT_WIDTH-1:0]  counter_in [BUTTONS];
   logic [BUTTONS-1:0]      pushed_ff;
   logic [BUTTONS-1:0]      pushed_in;
   logic                    latch_ff;
   logic                    latch_in;

   // input register
   logic                              in_valid_ff;
   logic [bcpd_pkg::PIN_WIDTH-1:0]    in_pins_ff;

   // result register
   logic                              rsp_valid_ff;
   logic                              event_valid_ff;
   logic                              event_valid_in;
   logic [1:0]                        event_button_ff;
   logic [1:0]                        event_button_in;
   logic                              event_latched_ff;
   logic [bcpd_pkg::SLOTS-1:0]        pushed_mask_ff;

   logic                              advance;
   logic                              load;
   logic                              csr_write;
   bcpd_pkg::reg_index_type           csr_index;

   // pipeline control
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign load      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // register port decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = bcpd_pkg::reg_index_type'(csr_paddr[5:3]);

   // register read back
   always_comb begin
      case (csr_index)
         bcpd_pkg::REG_BUTTON_COUNT:  csr_prdata = bcpd_pkg::DATA_WIDTH'(button_count_ff);
         bcpd_pkg::REG_BUTTON_ENABLE: csr_prdata = bcpd_pkg::DATA_WIDTH'(button_enable_ff);
         bcpd_pkg::REG_COMBO_MASKS:   csr_prdata = bcpd_pkg::DATA_WIDTH'(combo_masks_ff);
         bcpd_pkg::REG_HOLD_TICKS:    csr_prdata = bcpd_pkg::DATA_WIDTH'(hold_ticks_ff);
         bcpd_pkg::REG_EVENT_MODES:   csr_prdata = bcpd_pkg::DATA_WIDTH'(event_modes_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         button_count_ff  <= bcpd_pkg::BUTTON_COUNT_RESET;
         button_enable_ff <= bcpd_pkg::BUTTON_ENABLE_RESET;
         combo_masks_ff   <= '0;
         hold_ticks_ff    <= '0;
         event_modes_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            bcpd_pkg::REG_BUTTON_COUNT:
               button_count_ff <= csr_pwdata[bcpd_pkg::COUNT_REG_WIDTH-1:0];
            bcpd_pkg::REG_BUTTON_ENABLE:
               button_enable_ff <= csr_pwdata[bcpd_pkg::SLOTS-1:0];
            bcpd_pkg::REG_COMBO_MASKS:
               combo_masks_ff <= csr_pwdata[bcpd_pkg::SLOTS*bcpd_pkg::PIN_WIDTH-1:0];
            bcpd_pkg::REG_HOLD_TICKS:
               hold_ticks_ff <= csr_pwdata[bcpd_pkg::SLOTS*bcpd_pkg::HOLD_WIDTH-1:0];
            bcpd_pkg::REG_EVENT_MODES:
               event_modes_ff <= csr_pwdata[bcpd_pkg::SLOTS*bcpd_pkg::MODE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_pins_ff <= req_pressed_pins & PIN_MASK;
      end
   end

   // button priority chain, buttons in index order
   always_comb begin
      logic                             fired;
      logic [1:0]                       who;
      logic                             lat;
      logic [bcpd_pkg::PIN_WIDTH-1:0]   pins;
      logic [bcpd_pkg::PIN_WIDTH-1:0]   combo;
      logic [COUNT_WIDTH-1:0]           hold;
      bcpd_pkg::mode_type               mode;
      logic                             enabled;
      logic                             full_match;
      logic                             fire_hold;
      logic                             fire_break;

      pins       = in_pins_ff;
      fired      = 1'b0;
      who        = '0;
      lat        = latch_ff;
      counter_in = counter_ff;
      pushed_in  = pushed_ff;

      for (int i = 0; i < BUTTONS; i++) begin
         combo   = bcpd_pkg::PIN_WIDTH'(combo_masks_ff >> (bcpd_pkg::PIN_WIDTH * i));
         hold    = COUNT_WIDTH'(bcpd_pkg::HOLD_WIDTH'(
                      hold_ticks_ff >> (bcpd_pkg::HOLD_WIDTH * i)));
         mode    = bcpd_pkg::mode_type'(bcpd_pkg::MODE_WIDTH'(
                      event_modes_ff >> (bcpd_pkg::MODE_WIDTH * i)));
         enabled = (i < bcpd_pkg::SLOTS) && 1'(button_enable_ff >> i);
         full_match = (pins == combo);
         fire_hold  = (mode == bcpd_pkg::MODE_OVERFLOW) || (mode == bcpd_pkg::MODE_STATUS);
         fire_break = (mode == bcpd_pkg::MODE_BREAK) || (mode == bcpd_pkg::MODE_STATUS);

         if (i < int'(button_count_ff)) begin
            if (!lat) begin
               if (enabled) begin
                  if (full_match && !pushed_in[i]) begin
                     // still counting up to the hold time
                     if (counter_in[i] < hold) begin
                        counter_in[i] = counter_in[i] + 1'b1;
                     end else begin
                        pushed_in[i] = 1'b1;
                     end
                  end else if (full_match) begin
                     // held past the hold time
                     if (fire_hold) begin
                        fired = 1'b1;
                        who   = 2'(i);
                        lat   = 1'b1;
                     end
                  end else if (((pins & combo) != combo) && pushed_in[i]) begin
                     // released after being pushed
                     if (fire_break) begin
                        fired = 1'b1;
                        who   = 2'(i);
                        lat   = 1'b1;
                     end
                     pushed_in[i] = 1'b0;
                  end else begin
                     pushed_in[i]  = 1'b0;
                     counter_in[i] = '0;
                  end
               end
            end else if (pins == '0) begin
               // all pins up: clear every button in use and the latch
               for (int z = 0; z < BUTTONS; z++) begin
                  if (z < int'(button_count_ff)) begin
                     counter_in[z] = '0;
                     pushed_in[z]  = 1'b0;
                  end
               end
               lat = 1'b0;
            end
         end
      end

      latch_in        = lat;
      event_valid_in  = fired;
      event_button_in = who;
   end

   // button state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTONS; i++) begin
            counter_ff[i] <= '0;
         end
         pushed_ff <= '0;
         latch_ff  <= 1'b0;
      end else if (load) begin
         counter_ff <= counter_in;
         pushed_ff  <= pushed_in;
         latch_ff   <= latch_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
      if (load) begin
         event_valid_ff   <= event_valid_in;
         event_button_ff  <= event_button_in;
         event_latched_ff <= latch_in;
         pushed_mask_ff   <= bcpd_pkg::SLOTS'(pushed_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_valid   = event_valid_ff;
   assign rsp_event_button  = event_button_ff;
   assign rsp_event_latched = event_latched_ff;
   assign rsp_pushed_mask   = pushed_mask_ff;

   // input side only stalls behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // a shown result matches the button state it left behind
   a_result_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pushed_mask == bcpd_pkg::SLOTS'(pushed_ff))
                     && (rsp_event_latched == latch_ff)))
      else $error("result disagrees with button state");

   // with the latch set and some pin down, a tick fires nothing
   a_latched_quiet: assert property (@(posedge clock) disable iff (reset)
      (load && latch_ff && (in_pins_ff != '0)) |=> (rsp_valid && !rsp_event_valid))
      else $error("event fired while latched");

endmodule

FILE: tb/tb_button_combo_press_detector_core.sv
// testbench for the button combo press detector core: directed and random scan ticks
`timescale 1ns / 100ps

module tb_button_combo_press_detector_core;

   localparam int NUM_BUTTONS = 4;
   localparam int CYCLE_LIMIT = 200000;

   // one result transfer, as seen on the rsp_ channel
   typedef struct packed {
      logic                          ev_valid;
      logic [1:0]                    ev_button;
      logic                          latched;
      logic [bcpd_pkg::SLOTS-1:0]    pushed;
   } tick_report_type;

   // dut signals
   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [bcpd_pkg::PIN_WIDTH-1:0]     req_pressed_pins = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_event_valid;
   logic [1:0]                         rsp_event_button;
   logic                               rsp_event_latched;
   logic [bcpd_pkg::SLOTS-1:0]         rsp_pushed_mask;
   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [bcpd_pkg::ADDR_WIDTH-1:0]    csr_paddr = '0;
   logic [bcpd_pkg::DATA_WIDTH-1:0]    csr_pwdata = '0;
   logic [bcpd_pkg::DATA_WIDTH-1:0]    csr_prdata;
   logic                               csr_pready;

   // predictor copy of the configuration
   logic [bcpd_pkg::COUNT_REG_WIDTH-1:0]  cfg_count;
   logic [bcpd_pkg::SLOTS-1:0]            cfg_enable;
   logic [31:0]                           cfg_combos;
   logic [63:0]                           cfg_holds;
   logic [7:0]                            cfg_modes;

   // predictor copy of the button state
   logic [bcpd_pkg::HOLD_WIDTH-1:0]       hold_cnt [NUM_BUTTONS];
   logic                                  pushed_flags [NUM_BUTTONS];
   logic                                  event_latch;

   tick_report_type              pending_reports [$];
   tick_report_type              got_report;
   tick_report_type              want_report;
   int                           mismatch_count = 0;
   int                           ticks_sent = 0;
   int                           sender_idle_pct = 0;
   int                           recv_idle_pct = 0;
   int                           holdoff_cycles = 0;
   int                           cycle_count = 0;

   button_combo_press_detector_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pressed_pins  (req_pressed_pins),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_valid   (rsp_event_valid),
      .rsp_event_button  (rsp_event_button),
      .rsp_event_latched (rsp_event_latched),
      .rsp_pushed_mask   (rsp_pushed_mask),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // 10 ns clock
   always #5 clock = ~clock;

   // predictor state and configuration after reset
   task automatic reset_detector_model();
      cfg_count = bcpd_pkg::BUTTON_COUNT_RESET;
      cfg_enable = bcpd_pkg::BUTTON_ENABLE_RESET;
      cfg_combos = '0;
      cfg_holds = '0;
      cfg_modes = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         hold_cnt[b] = '0;
         pushed_flags[b] = 1'b0;
      end
      event_latch = 1'b0;
   endtask

   // one scan tick through the button priority chain
   function automatic tick_report_type detect_tick(
         input logic [bcpd_pkg::PIN_WIDTH-1:0] pins);
      tick_report_type     rep;
      int                  n;
      logic [7:0]          combo;
      logic [15:0]         hold;
      bcpd_pkg::mode_type  mode;
      rep = '0;
      n = (cfg_count > NUM_BUTTONS) ? NUM_BUTTONS : int'(cfg_count);
      for (int b = 0; b < n; b++) begin
         if (!event_latch) begin
            if (cfg_enable[b]) begin
               combo = cfg_combos[8*b +: 8];
               hold = cfg_holds[16*b +: 16];
               mode = bcpd_pkg::mode_type'(cfg_modes[2*b +: 2]);
               if (pins == combo && !pushed_flags[b]) begin
                  if (hold_cnt[b] < hold)
                     hold_cnt[b] = hold_cnt[b] + 16'd1;
                  else
                     pushed_flags[b] = 1'b1;
               end else if (pins == combo) begin
                  // held past the count
                  if (mode == bcpd_pkg::MODE_OVERFLOW || mode == bcpd_pkg::MODE_STATUS) begin
                     rep.ev_valid = 1'b1;
                     rep.ev_button = 2'(b);
                     event_latch = 1'b1;
                  end
               end else if ((pins & combo) != combo && pushed_flags[b]) begin
                  // released after being pushed
                  if (mode == bcpd_pkg::MODE_BREAK || mode == bcpd_pkg::MODE_STATUS) begin
                     rep.ev_valid = 1'b1;
                     rep.ev_button = 2'(b);
                     event_latch = 1'b1;
                  end
                  pushed_flags[b] = 1'b0;
               end else begin
                  pushed_flags[b] = 1'b0;
                  hold_cnt[b] = '0;
               end
            end
         end else if (pins == '0) begin
            // latch set and all pins up: clear every button in use
            for (int z = 0; z < n; z++) begin
               hold_cnt[z] = '0;
               pushed_flags[z] = 1'b0;
            end
            event_latch = 1'b0;
         end
      end
      rep.latched = event_latch;
      for (int b = 0; b < NUM_BUTTONS; b++)
         rep.pushed[b] = pushed_flags[b];
      return rep;
   endfunction

   // apb write: setup cycle, access cycle, then back to idle
   task automatic csr_write(input bcpd_pkg::reg_index_type idx,
                            input logic [bcpd_pkg::DATA_WIDTH-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         bcpd_pkg::REG_BUTTON_COUNT:  cfg_count = value[bcpd_pkg::COUNT_REG_WIDTH-1:0];
         bcpd_pkg::REG_BUTTON_ENABLE: cfg_enable = value[bcpd_pkg::SLOTS-1:0];
         bcpd_pkg::REG_COMBO_MASKS:   cfg_combos = value[31:0];
         bcpd_pkg::REG_HOLD_TICKS:    cfg_holds = value;
         bcpd_pkg::REG_EVENT_MODES:   cfg_modes = value[7:0];
         default: ;
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all_regs(input logic [2:0] count, input logic [3:0] enable,
                                 input logic [31:0] combos, input logic [63:0] holds,
                                 input logic [7:0] modes);
      csr_write(bcpd_pkg::REG_BUTTON_COUNT, 64'(count));
      csr_write(bcpd_pkg::REG_BUTTON_ENABLE, 64'(enable));
      csr_write(bcpd_pkg::REG_COMBO_MASKS, 64'(combos));
      csr_write(bcpd_pkg::REG_HOLD_TICKS, holds);
      csr_write(bcpd_pkg::REG_EVENT_MODES, 64'(modes));
   endtask

   // offer one tick, wait for its transfer, record the expected report
   task automatic send_tick(input logic [bcpd_pkg::PIN_WIDTH-1:0] pins);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pressed_pins <= pins;
      do @(posedge clock); while (req_stall);
      pending_reports.push_back(detect_tick(pins));
      ticks_sent++;
   endtask

   task automatic send_repeat(input logic [bcpd_pkg::PIN_WIDTH-1:0] pins, input int n);
      repeat (n) send_tick(pins);
   endtask

   // stop offering and let every outstanding report come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // receiver side: random stall plus an optional long hold-off
   always @(posedge clock) begin
      if (holdoff_cycles > 0) begin
         holdoff_cycles = holdoff_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // compare each result transfer with the oldest expected report
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_report = '{rsp_event_valid, rsp_event_button, rsp_event_latched,
                        rsp_pushed_mask};
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result at cycle %0d: ev %b btn %0d latch %b pushed %b",
                        cycle_count, got_report.ev_valid, got_report.ev_button,
                        got_report.latched, got_report.pushed);
         end else begin
            want_report = pending_reports.pop_front();
            if (got_report.ev_valid !== want_report.ev_valid ||
                got_report.ev_button !== want_report.ev_button ||
                got_report.latched !== want_report.latched ||
                got_report.pushed !== want_report.pushed) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at cycle %0d: %s, %s", cycle_count,
                           $sformatf("expected ev %b btn %0d latch %b pushed %b",
                                     want_report.ev_valid, want_report.ev_button,
                                     want_report.latched, want_report.pushed),
                           $sformatf("got ev %b btn %0d latch %b pushed %b",
                                     got_report.ev_valid, got_report.ev_button,
                                     got_report.latched, got_report.pushed));
            end
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // default registers: no buttons in use
   task automatic test_reset_defaults();
      send_tick(8'h00);
      send_tick(8'hff);
   endtask

   // each event mode on its own button
   task automatic test_event_modes();
      wait_drained();
      write_all_regs(3'd4, 4'hf, 32'hf00c_0301, 64'h0001_0002_0001_0000,
                     {bcpd_pkg::MODE_NONE, bcpd_pkg::MODE_STATUS,
                      bcpd_pkg::MODE_BREAK, bcpd_pkg::MODE_OVERFLOW});
      // overflow on button 0, then release clears the latch
      send_repeat(8'h01, 3);
      send_tick(8'h00);
      // break on button 1
      send_repeat(8'h03, 3);
      send_tick(8'h02);
      send_tick(8'h00);
      // status mode on button 2, break side
      send_repeat(8'h0c, 3);
      send_tick(8'h08);
      send_tick(8'h00);
      // no event for button 3
      send_repeat(8'hf0, 3);
      send_tick(8'h70);
      send_tick(8'h00);
   endtask

   // empty combo: the latch clears in the same tick the event fires
   task automatic test_zero_combo_latch_clear();
      wait_drained();
      write_all_regs(3'd4, 4'hf, 32'h0000_0000, 64'h0, 8'h00);
      send_repeat(8'h00, 3);
   endtask

   // count above the button number, all disabled, then all-ones registers
   task automatic test_register_extremes();
      wait_drained();
      write_all_regs(3'd7, 4'h0, 32'h0101_0101, 64'h0, 8'h00);
      send_repeat(8'h01, 2);
      wait_drained();
      write_all_regs(3'd7, 4'hf, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 8'hff);
      send_repeat(8'hff, 2);
   endtask

   // random configuration: short holds mostly, extremes now and then
   task automatic randomize_config();
      logic [2:0]  count;
      logic [3:0]  enable;
      logic [31:0] combos;
      logic [63:0] holds;
      logic [7:0]  modes;
      count = ($urandom_range(99) < 60) ? 3'd4 : 3'($urandom_range(7));
      enable = ($urandom_range(99) < 60) ? 4'hf : 4'($urandom);
      combos = $urandom;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         if ($urandom_range(99) < 12) combos[8*b +: 8] = 8'h00;
         holds[16*b +: 16] = ($urandom_range(99) < 8) ? 16'hffff : 16'($urandom_range(5));
      end
      // nested combos so that several buttons see the same pins
      if ($urandom_range(99) < 30) combos[15:8] = combos[7:0] | 8'($urandom);
      modes = $urandom;
      case ($urandom_range(9))
         0: begin combos = '0; modes = '0; end
         1: begin combos = '1; modes = '1; end
         2: holds = '0;
         default: ;
      endcase
      wait_drained();
      write_all_regs(count, enable, combos, holds, modes);
   endtask

   // press sequences with random content, plus noise
   task automatic send_random_sequence();
      int          choice;
      int          b;
      int          len;
      logic [7:0]  combo;
      logic [15:0] hold;
      choice = $urandom_range(99);
      b = $urandom_range(NUM_BUTTONS - 1);
      combo = cfg_combos[8*b +: 8];
      hold = cfg_holds[16*b +: 16];
      if (choice < 65) begin
         // hold the combo for its count (capped at 8) plus 1 to 4 ticks, then release all or some pins
         len = ((hold > 8) ? 8 : int'(hold)) + $urandom_range(1, 4);
         send_repeat(combo, len);
         if (choice < 40)
            send_tick(8'h00);
         else
            send_tick(combo & 8'($urandom));
      end else if (choice < 80) begin
         send_tick(8'h00);
      end else if (choice < 90) begin
         send_tick(combo ^ (8'h01 << $urandom_range(7)));
      end else begin
         send_tick(8'($urandom));
      end
   endtask

   task automatic test_random_traffic(input int items, input int s_pct, input int r_pct);
      int target;
      int next_config;
      target = ticks_sent + items;
      next_config = ticks_sent;
      sender_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      while (ticks_sent < target) begin
         if (ticks_sent >= next_config) begin
            randomize_config();
            next_config = ticks_sent + $urandom_range(60, 160);
         end
         send_random_sequence();
      end
   endtask

   // receiver holds off for a long stretch while ticks keep coming
   task automatic test_receiver_holdoff();
      randomize_config();
      sender_idle_pct = 0;
      holdoff_cycles = 300;
      repeat (40) send_random_sequence();
   endtask

   // sender pauses until every report is back, then resumes
   task automatic test_sender_pause();
      sender_idle_pct = 11;
      recv_idle_pct = 45;
      repeat (10) send_random_sequence();
      wait_drained();
      repeat (10) send_random_sequence();
   endtask

   initial begin
      reset_detector_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 11;
      recv_idle_pct = 45;
      test_reset_defaults();
      test_event_modes();
      test_zero_combo_latch_clear();
      test_register_extremes();
      test_receiver_holdoff();
      test_sender_pause();
      test_random_traffic(500, 11, 45);
      test_random_traffic(500, 45, 11);
      test_random_traffic(500, 0, 0);
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_reports.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
